// ----- hw/rtl/vertex_rotate_project_core_defines.svh -----
// assertion macros for the vertex rotate and project core
`ifndef VERTEX_ROTATE_PROJECT_CORE_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_CORE_DEFINES_SVH

// assertion checked outside reset
`define VRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// assertion checked in every cycle, reset included
`define VRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/vrp_pkg.sv -----
// shared constants and types for the vertex rotate and project core
`timescale 1ns / 1ps
package vrp_pkg;

    // pipeline layout
    localparam int DIV_NW     = 44;
    localparam int DIV_DW     = 32;
    localparam int DIV_FIRST  = 3;
    localparam int NUM_STAGES = DIV_FIRST + DIV_NW + 3;

    // configuration register indexes
    localparam logic [2:0] REG_COS_ANGLE   = 3'd0;
    localparam logic [2:0] REG_SIN_ANGLE   = 3'd1;
    localparam logic [2:0] REG_Z_OFFSET    = 3'd2;
    localparam logic [2:0] REG_VIEW_WIDTH  = 3'd3;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEHIND = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    typedef struct packed {
        logic behind;
        logic neg_x;
        logic neg_y;
    } side_t;

    localparam int DIV_SW = $bits(side_t);

endpackage

// ----- hw/rtl/vrp_div.sv -----
// pipelined restoring divider, two numerators over one divisor, one bit per stage
`timescale 1ns / 1ps
module vrp_div
    import vrp_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int SW = DIV_SW
) (
    input  logic          aclk,
    input  logic [NW-1:0] en,
    input  logic [NW-1:0] num_x,
    input  logic [NW-1:0] num_y,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic [NW-1:0] quo_x,
    output logic [NW-1:0] quo_y,
    output logic          rem_nz_x,
    output logic          rem_nz_y,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rx_reg [NW];
    logic [DW-1:0] ry_reg [NW];
    logic [NW-1:0] nx_reg [NW];
    logic [NW-1:0] ny_reg [NW];
    logic [DW-1:0] d_reg  [NW];
    logic [SW-1:0] sd_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [DW-1:0] rx_prev, ry_prev, d_prev;
            logic [NW-1:0] nx_prev, ny_prev;
            logic [SW-1:0] sd_prev;
            logic [DW:0]   tx, ty;
            logic          gx, gy;
            if (k == 0) begin : g_head
                assign rx_prev = '0;
                assign ry_prev = '0;
                assign nx_prev = num_x;
                assign ny_prev = num_y;
                assign d_prev  = den;
                assign sd_prev = side_in;
            end else begin : g_body
                assign rx_prev = rx_reg[k-1];
                assign ry_prev = ry_reg[k-1];
                assign nx_prev = nx_reg[k-1];
                assign ny_prev = ny_reg[k-1];
                assign d_prev  = d_reg[k-1];
                assign sd_prev = sd_reg[k-1];
            end
            assign tx = {rx_prev, nx_prev[NW-1]};
            assign ty = {ry_prev, ny_prev[NW-1]};
            assign gx = tx >= {1'b0, d_prev};
            assign gy = ty >= {1'b0, d_prev};
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rx_reg[k] <= gx ? DW'(tx - {1'b0, d_prev}) : tx[DW-1:0];
                    ry_reg[k] <= gy ? DW'(ty - {1'b0, d_prev}) : ty[DW-1:0];
                    nx_reg[k] <= {nx_prev[NW-2:0], gx};
                    ny_reg[k] <= {ny_prev[NW-2:0], gy};
                    d_reg[k]  <= d_prev;
                    sd_reg[k] <= sd_prev;
                end
            end
        end
    endgenerate

    assign quo_x    = nx_reg[NW-1];
    assign quo_y    = ny_reg[NW-1];
    assign rem_nz_x = |rx_reg[NW-1];
    assign rem_nz_y = |ry_reg[NW-1];
    assign side_out = sd_reg[NW-1];

endmodule

// ----- hw/rtl/vertex_rotate_project_core.sv -----
// vertex rotate and perspective project core, top level
// usage:
//   s_ channel takes one vertex per beat, s_tdata = {z, y, x}, each signed q3.12
//   m_ channel gives one result beat per vertex: pixel x, pixel y and status
//   status 0 ok, 1 vertex behind the viewer (pixels zero), 2 a pixel clamped
//   cfg_wr_en/cfg_index/cfg_wdata write cos, sin, z offset, view width, height;
//   write only while no vertex is in flight
// timing:
//   latency is 50 cycles from accepted input beat to output beat
//   one vertex per cycle sustained; 44 of the stages are the bit-per-stage
//   divider that forms x/z and y/z
//   each stage holds a valid bit; a stalled m_tready fills empty stages first,
//   so s_tready drops only when every stage holds a vertex
// reset:
//   aresetn clears all valid bits and loads cos 1.0, sin 0, z offset 1.0,
//   view 800 by 800
`timescale 1ns / 1ps
module vertex_rotate_project_core
    import vrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x, pixel_y, status, zero pad
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int F1 = DIV_FIRST + DIV_NW;
    localparam int F2 = F1 + 1;
    localparam int FO = F2 + 1;
    localparam logic signed [30:0] C_HI = 31'sh3fffffff;
    localparam logic signed [30:0] C_LO = -31'sh40000000;

    logic signed [15:0] cos_reg, sin_reg, zoff_reg;
    logic [12:0]        vw_reg, vh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg  <= 16'sd16384;
            sin_reg  <= 16'sd0;
            zoff_reg <= 16'sd4096;
            vw_reg   <= 13'd800;
            vh_reg   <= 13'd800;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COS_ANGLE:   cos_reg  <= signed'(cfg_wdata);
                REG_SIN_ANGLE:   sin_reg  <= signed'(cfg_wdata);
                REG_Z_OFFSET:    zoff_reg <= signed'(cfg_wdata);
                REG_VIEW_WIDTH:  vw_reg   <= cfg_wdata[12:0];
                REG_VIEW_HEIGHT: vh_reg   <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // valid bits and bubble-collapsing ready chain
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES - 1; g++) begin : g_rdy
            assign rdy[g] = !vld_reg[g] || rdy[g+1];
        end
    endgenerate
    assign rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];

    // stage 1: products
    logic signed [15:0] in_x, in_y, in_z;
    logic signed [31:0] p_xc_reg, p_zs_reg, p_xs_reg, p_zc_reg;
    logic signed [15:0] y1_reg, y2_reg;

    assign in_x = signed'(s_tdata[15:0]);
    assign in_y = signed'(s_tdata[31:16]);
    assign in_z = signed'(s_tdata[47:32]);

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            p_xc_reg <= in_x * cos_reg;
            p_zs_reg <= in_z * sin_reg;
            p_xs_reg <= in_x * sin_reg;
            p_zc_reg <= in_z * cos_reg;
            y1_reg   <= in_y;
        end
    end

    // stage 2: rotated x and depth
    logic signed [32:0] xr_reg;
    logic signed [33:0] zr_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            xr_reg <= 33'(p_xc_reg) - 33'(p_zs_reg);
            zr_reg <= 34'(p_xs_reg) + 34'(p_zc_reg) + (34'(zoff_reg) <<< 14);
            y2_reg <= y1_reg;
        end
    end

    // stage 3: magnitudes and signs for the divider
    logic [32:0]        xr_abs;
    logic [16:0]        y_abs;
    logic [DIV_NW-1:0]  numx_reg, numy_reg;
    logic [DIV_DW-1:0]  den_reg;
    side_t              sd3_reg, sd_div;

    assign xr_abs = xr_reg[32] ? 33'(-xr_reg) : 33'(xr_reg);
    assign y_abs  = y2_reg[15] ? 17'(-17'(y2_reg)) : 17'(y2_reg);

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            numx_reg       <= {xr_abs[31:0], 12'b0};
            numy_reg       <= {2'b0, y_abs[15:0], 26'b0};
            den_reg        <= zr_reg[DIV_DW-1:0];
            sd3_reg.behind <= zr_reg[33] || (zr_reg == '0);
            sd3_reg.neg_x  <= xr_reg[32];
            sd3_reg.neg_y  <= y2_reg[15];
        end
    end

    logic [DIV_NW-1:0] qx, qy;
    logic              rnz_x, rnz_y;

    vrp_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .SW (DIV_SW)
    ) u_div (
        .aclk     (aclk),
        .en       (rdy[F1-1:DIV_FIRST]),
        .num_x    (numx_reg),
        .num_y    (numy_reg),
        .den      (den_reg),
        .side_in  (sd3_reg),
        .quo_x    (qx),
        .quo_y    (qy),
        .rem_nz_x (rnz_x),
        .rem_nz_y (rnz_y),
        .side_out (sd_div)
    );

    // floor fix, center offset, clamp
    logic signed [45:0] qxe, qye, cx, cy;
    logic signed [30:0] cx_reg, cy_reg;
    side_t              sd_f1_reg, sd_f2_reg;

    assign qxe = signed'({2'b0, qx});
    assign qye = signed'({2'b0, qy});
    assign cx  = sd_div.neg_x ? (~qxe) + 46'sd4096 + signed'({45'b0, !rnz_x})
                              : qxe + 46'sd4096;
    assign cy  = sd_div.neg_y ? qye + 46'sd4097 - signed'({45'b0, !rnz_y})
                              : 46'sd4096 - qye;

    always_ff @(posedge aclk) begin
        if (rdy[F1]) begin
            cx_reg    <= (cx > 46'(C_HI)) ? C_HI : (cx < 46'(C_LO)) ? C_LO : 31'(cx);
            cy_reg    <= (cy > 46'(C_HI)) ? C_HI : (cy < 46'(C_LO)) ? C_LO : 31'(cy);
            sd_f1_reg <= sd_div;
        end
    end

    // scale by view size
    logic signed [44:0] mx_reg, my_reg;

    always_ff @(posedge aclk) begin
        if (rdy[F2]) begin
            mx_reg    <= 45'(cx_reg) * 45'(signed'({1'b0, vw_reg}));
            my_reg    <= 45'(cy_reg) * 45'(signed'({1'b0, vh_reg}));
            sd_f2_reg <= sd_f1_reg;
        end
    end

    // divide by 8192 with floor, saturate, status
    logic signed [44:0] sx, sy;
    logic signed [15:0] px, py;
    logic               sat_x, sat_y;
    logic [15:0]        px_reg, py_reg;
    logic [1:0]         st_reg;

    assign sx    = mx_reg >>> 13;
    assign sy    = my_reg >>> 13;
    assign sat_x = (sx > 45'sd32767) || (sx < -45'sd32768);
    assign sat_y = (sy > 45'sd32767) || (sy < -45'sd32768);
    assign px    = (sx > 45'sd32767) ? 16'sh7fff : (sx < -45'sd32768) ? -16'sh8000 : 16'(sx);
    assign py    = (sy > 45'sd32767) ? 16'sh7fff : (sy < -45'sd32768) ? -16'sh8000 : 16'(sy);

    always_ff @(posedge aclk) begin
        if (rdy[FO]) begin
            if (sd_f2_reg.behind) begin
                px_reg <= '0;
                py_reg <= '0;
                st_reg <= ST_BEHIND;
            end else begin
                px_reg <= px;
                py_reg <= py;
                st_reg <= (sat_x || sat_y) ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_tdata = {6'b0, st_reg, py_reg, px_reg};

endmodule

// ----- hw/rtl/vrp_checker.sv -----
// port-level assertions for the vertex rotate and project core, with bind
`timescale 1ns / 1ps
`include "vertex_rotate_project_core_defines.svh"
module vrp_port_checker
    import vrp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `VRP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `VRP_ASSERT(a_behind_zero, m_tvalid && (m_tdata[33:32] == ST_BEHIND) |-> (m_tdata[31:0] == 32'd0), "behind vertex with nonzero pixels")
    `VRP_ASSERT(a_status_code, m_tvalid |-> (m_tdata[33:32] <= ST_SAT) && (m_tdata[39:34] == 6'd0), "bad status or pad bits")
    `VRP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid right after reset")

endmodule

bind vertex_rotate_project_core vrp_port_checker u_vrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
